>>> rtl/psg_pkg.sv
// ----------------------------------------------------------------------------
// psg_pkg
// Shared types, constants and the volume table of the tone and noise
// generator.
// ----------------------------------------------------------------------------
package psg_pkg;

    localparam int NUM_TONE  = 3;
    localparam int NUM_CHAN  = 4;
    localparam int PERIOD_W  = 10;
    localparam int ATT_W     = 4;
    localparam int NCTL_W    = 3;
    localparam int SHIFT_W   = 16;
    localparam int SAMPLE_W  = 8;

    localparam logic [1:0]         CH_NOISE    = 2'd3;
    localparam logic [SHIFT_W-1:0] NOISE_SEED  = 16'h8000;
    localparam logic [SHIFT_W-1:0] NOISE_TAPS  = 16'h0009;
    localparam logic [ATT_W-1:0]   ATT_SILENT  = 4'hF;

    // Noise rate codes (noise control bits 1..0)
    localparam logic [1:0] RATE_16   = 2'd0;
    localparam logic [1:0] RATE_32   = 2'd1;
    localparam logic [1:0] RATE_64   = 2'd2;
    localparam logic [1:0] RATE_TONE = 2'd3;

    localparam logic [PERIOD_W-1:0] RELOAD_16 = 10'h010;
    localparam logic [PERIOD_W-1:0] RELOAD_32 = 10'h020;
    localparam logic [PERIOD_W-1:0] RELOAD_64 = 10'h040;

    // Programmed registers handed from the register file to the channels
    // and the mixer, with the pulse that reseeds the noise shifter.
    typedef struct packed {
        logic [NUM_TONE-1:0][PERIOD_W-1:0] tone_period;
        logic [NCTL_W-1:0]                 noise_control;
        logic [NUM_CHAN-1:0][ATT_W-1:0]    attenuation;
        logic                              noise_seed;
    } psg_regs_t;

    // Channel weight: (255 * (15 - att) / 15) / 4
    function automatic logic [SAMPLE_W-1:0] vol_of(input logic [ATT_W-1:0] att);
        logic [SAMPLE_W-1:0] v;
        case (att)
            4'd0:    v = 8'd63;
            4'd1:    v = 8'd59;
            4'd2:    v = 8'd55;
            4'd3:    v = 8'd51;
            4'd4:    v = 8'd46;
            4'd5:    v = 8'd42;
            4'd6:    v = 8'd38;
            4'd7:    v = 8'd34;
            4'd8:    v = 8'd29;
            4'd9:    v = 8'd25;
            4'd10:   v = 8'd21;
            4'd11:   v = 8'd17;
            4'd12:   v = 8'd12;
            4'd13:   v = 8'd8;
            4'd14:   v = 8'd4;
            default: v = 8'd0;
        endcase
        return v;
    endfunction

endpackage

>>> rtl/psg_in_if.sv
// ----------------------------------------------------------------------------
// psg_in_if
// Input channel: one bus write or one generator tick per transaction.
// ----------------------------------------------------------------------------
interface psg_in_if;
    logic       valid;
    logic       ready;
    logic       command;
    logic [7:0] data_byte;

    modport source (output valid, output command, output data_byte, input ready);
    modport sink   (input valid, input command, input data_byte, output ready);
endinterface

>>> rtl/psg_out_if.sv
// ----------------------------------------------------------------------------
// psg_out_if
// Output channel: one mixed audio sample per transaction.
// ----------------------------------------------------------------------------
interface psg_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

>>> rtl/psg_regfile.sv
// ----------------------------------------------------------------------------
// psg_regfile
// Decodes latch and data bytes into the tone, volume and noise registers.
// ----------------------------------------------------------------------------
module psg_regfile (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr,
    input  logic [7:0]        data_byte,
    output psg_pkg::psg_regs_t regs
);
    import psg_pkg::*;

    logic [NUM_TONE-1:0][PERIOD_W-1:0] tone_reg, tone_next;
    logic [NCTL_W-1:0]                 nctl_reg, nctl_next;
    logic [NUM_CHAN-1:0][ATT_W-1:0]    att_reg, att_next;
    logic                              lvol_reg, lvol_next;
    logic [1:0]                        lch_reg, lch_next;

    always_comb
    begin
        tone_next = tone_reg;
        nctl_next = nctl_reg;
        att_next  = att_reg;
        lvol_next = lvol_reg;
        lch_next  = lch_reg;
        if (wr)
        begin
            if (data_byte[7])
            begin
                lvol_next = data_byte[4];
                lch_next  = data_byte[6:5];
                if (data_byte[4])
                begin
                    att_next[data_byte[6:5]] = data_byte[3:0];
                end
                else if (data_byte[6:5] == CH_NOISE)
                begin
                    nctl_next = data_byte[2:0];
                end
                else
                begin
                    for (int i = 0; i < NUM_TONE; i++)
                    begin
                        if (data_byte[6:5] == 2'(i))
                        begin
                            tone_next[i][3:0] = data_byte[3:0];
                        end
                    end
                end
            end
            else
            begin
                if (lvol_reg)
                begin
                    att_next[lch_reg] = data_byte[3:0];
                end
                else if (lch_reg == CH_NOISE)
                begin
                    nctl_next = data_byte[2:0];
                end
                else
                begin
                    for (int i = 0; i < NUM_TONE; i++)
                    begin
                        if (lch_reg == 2'(i))
                        begin
                            tone_next[i][9:4] = data_byte[5:0];
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tone_reg <= '0;
            nctl_reg <= '0;
            att_reg  <= {NUM_CHAN{ATT_SILENT}};
            lvol_reg <= 1'b0;
            lch_reg  <= 2'd0;
        end
        else
        begin
            tone_reg <= tone_next;
            nctl_reg <= nctl_next;
            att_reg  <= att_next;
            lvol_reg <= lvol_next;
            lch_reg  <= lch_next;
        end
    end

    always_comb
    begin
        regs.tone_period   = tone_reg;
        regs.noise_control = nctl_reg;
        regs.attenuation   = att_reg;
        // Any write that leaves the noise control register latched reseeds.
        regs.noise_seed    = wr && !lvol_next && (lch_next == CH_NOISE);
    end

endmodule

>>> rtl/psg_channels.sv
// ----------------------------------------------------------------------------
// psg_channels
// Down counters, phases and levels of the three tone channels and the noise
// channel, with the noise shifter.
// ----------------------------------------------------------------------------
module psg_channels (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               tick,
    input  psg_pkg::psg_regs_t regs,
    output logic [3:0]         level_next
);
    import psg_pkg::*;

    logic [NUM_CHAN-1:0][PERIOD_W-1:0] cnt_reg, cnt_next;
    logic [NUM_CHAN-1:0]               phase_reg, phase_next;
    logic [NUM_CHAN-1:0]               level_reg, level_reg_next;
    logic [SHIFT_W-1:0]                shift_reg, shift_next;

    logic [NUM_CHAN-1:0][PERIOD_W-1:0] cnt_dec;
    logic                              fb;
    logic [PERIOD_W-1:0]               noise_reload;

    always_comb
    begin
        for (int i = 0; i < NUM_CHAN; i++)
        begin
            cnt_dec[i] = (cnt_reg[i] != '0) ? cnt_reg[i] - PERIOD_W'(1) : '0;
        end

        case (regs.noise_control[1:0])
            RATE_16:   noise_reload = RELOAD_16;
            RATE_32:   noise_reload = RELOAD_32;
            RATE_64:   noise_reload = RELOAD_64;
            default:   noise_reload = regs.tone_period[2];
        endcase

        if (regs.noise_control[2])
        begin
            fb = ^(shift_reg & NOISE_TAPS);
        end
        else
        begin
            fb = shift_reg[0];
        end

        cnt_next       = cnt_reg;
        phase_next     = phase_reg;
        level_reg_next = level_reg;
        shift_next     = shift_reg;

        if (regs.noise_seed)
        begin
            shift_next = NOISE_SEED;
        end

        if (tick)
        begin
            for (int i = 0; i < NUM_TONE; i++)
            begin
                cnt_next[i] = cnt_dec[i];
                if (cnt_dec[i] == '0)
                begin
                    cnt_next[i] = regs.tone_period[i];
                    // A period of zero or one holds the output high.
                    if (regs.tone_period[i][PERIOD_W-1:1] == '0)
                    begin
                        phase_next[i]     = 1'b1;
                        level_reg_next[i] = 1'b1;
                    end
                    else
                    begin
                        phase_next[i]     = ~phase_reg[i];
                        level_reg_next[i] = ~phase_reg[i];
                    end
                end
            end

            cnt_next[CH_NOISE] = cnt_dec[CH_NOISE];
            if (cnt_dec[CH_NOISE] == '0)
            begin
                cnt_next[CH_NOISE]   = noise_reload;
                phase_next[CH_NOISE] = ~phase_reg[CH_NOISE];
                if (!phase_reg[CH_NOISE])
                begin
                    level_reg_next[CH_NOISE] = shift_reg[0];
                    shift_next               = {fb, shift_reg[SHIFT_W-1:1]};
                end
            end
        end

        level_next = level_reg_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            phase_reg <= '0;
            level_reg <= '0;
            shift_reg <= '0;
        end
        else
        begin
            cnt_reg   <= cnt_next;
            phase_reg <= phase_next;
            level_reg <= level_reg_next;
            shift_reg <= shift_next;
        end
    end

endmodule

>>> rtl/psg_mixer.sv
// ----------------------------------------------------------------------------
// psg_mixer
// Weights each high channel by its attenuation and sums the four weights.
// ----------------------------------------------------------------------------
module psg_mixer (
    input  logic [3:0]                          level,
    input  logic [3:0][3:0]                     attenuation,
    output logic [7:0]                          sample
);
    import psg_pkg::*;

    logic [SAMPLE_W-1:0] sum;

    always_comb
    begin
        sum = '0;
        for (int i = 0; i < NUM_CHAN; i++)
        begin
            if (level[i])
            begin
                sum = sum + vol_of(attenuation[i]);
            end
        end
        sample = sum;
    end

endmodule

>>> rtl/psg_out_skid.sv
// ----------------------------------------------------------------------------
// psg_out_skid
// Result register with a skid stage, so that input stays open while a
// sample waits to be taken.
// ----------------------------------------------------------------------------
module psg_out_skid (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  logic [7:0] push_sample,
    output logic       space,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_sample
);
    import psg_pkg::*;

    logic                main_valid_reg, main_valid_next;
    logic                skid_valid_reg, skid_valid_next;
    logic [SAMPLE_W-1:0] main_reg, main_next;
    logic [SAMPLE_W-1:0] skid_reg, skid_next;
    logic                pop;

    assign pop = main_valid_reg && out_ready;

    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                main_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (pop || !main_valid_reg)
            begin
                main_next       = push_sample;
                main_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = push_sample;
                skid_valid_next = 1'b1;
            end
        end
        else if (pop)
        begin
            main_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    assign space      = !skid_valid_reg;
    assign out_valid  = main_valid_reg;
    assign out_sample = main_reg;

endmodule

>>> rtl/psg_tone_noise_generator_top.sv
// ----------------------------------------------------------------------------
// psg_tone_noise_generator_top
// Three square-tone channels and one noise channel with an 8-bit mixer.
// ----------------------------------------------------------------------------
//  Port    Direction  Payload               Meaning
//  bus     in         command, data_byte    bus write (0) or generator tick (1)
//  audio   out        sample                mixed sample, one per tick
//
//  One transaction is taken every clock cycle while bus.ready is high; a
//  tick's sample is formed by the channel update and mixer logic and goes
//  into the result register, or into the skid register if that is full.
//  Reset sets all volumes to silent and clears periods, counters and levels.
//  The output has a two-entry buffer; bus.ready drops only when both entries
//  hold samples that have not been taken.
// ----------------------------------------------------------------------------
module psg_tone_noise_generator_top (
    input  logic      clk,
    input  logic      rst_n,
    psg_in_if.sink    bus,
    psg_out_if.source audio
);
    import psg_pkg::*;

    psg_regs_t           regs;
    logic                accept;
    logic                wr;
    logic                tick;
    logic [NUM_CHAN-1:0] level_next;
    logic [SAMPLE_W-1:0] mix;
    logic                space;

    assign accept = bus.valid && bus.ready;
    assign wr     = accept && !bus.command;
    assign tick   = accept && bus.command;

    psg_regfile u_regfile (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr        (wr),
        .data_byte (bus.data_byte),
        .regs      (regs)
    );

    psg_channels u_channels (
        .clk        (clk),
        .rst_n      (rst_n),
        .tick       (tick),
        .regs       (regs),
        .level_next (level_next)
    );

    psg_mixer u_mixer (
        .level       (level_next),
        .attenuation (regs.attenuation),
        .sample      (mix)
    );

    psg_out_skid u_out_skid (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (tick),
        .push_sample (mix),
        .space       (space),
        .out_valid   (audio.valid),
        .out_ready   (audio.ready),
        .out_sample  (audio.sample)
    );

    assign bus.ready = space;

endmodule

>>> bench/psg_tone_noise_generator_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// psg_tone_noise_generator_top_test
// Self-checking bench for the three-tone, one-noise sound generator. A short
// table of bus writes and ticks is followed by a random mix of both. Random
// gaps and stalls are applied on both channels. Every accepted tick is run
// through a behavioural model of the channels and the mixer, and each sample
// taken from the block is compared with the oldest prediction.
// ----------------------------------------------------------------------------
module psg_tone_noise_generator_top_test;

    import psg_pkg::*;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_TICK  = 1'b1;

    typedef struct packed {
        logic       cmd;
        logic [7:0] data;
        logic       typed;
        logic [7:0] sample;
    } step_t;

    logic clk = 1'b0;
    logic rst_n;

    psg_in_if  bus_if ();
    psg_out_if audio_if ();

    psg_tone_noise_generator_top uut (
        .clk   (clk),
        .rst_n (rst_n),
        .bus   (bus_if.sink),
        .audio (audio_if.source)
    );

    always #5 clk = ~clk;

    // Model state of the generator.
    logic [ATT_W-1:0]    att_r     [NUM_CHAN];
    logic [PERIOD_W-1:0] period_r  [NUM_TONE];
    logic [NCTL_W-1:0]   nctl_r;
    logic [PERIOD_W-1:0] count_r   [NUM_CHAN];
    logic                phase_r   [NUM_CHAN];
    logic                level_r   [NUM_CHAN];
    logic [SHIFT_W-1:0]  lfsr_r;
    logic                latch_vol_r;
    logic [1:0]          latch_ch_r;

    logic [SAMPLE_W-1:0] expected_samples [$];
    int                  fail_count    = 0;
    int                  samples_taken = 0;
    bit                  no_idle       = 1'b0;

    step_t directed_steps [0:25] = '{
        '{CMD_WRITE, 8'h2A, 1'b0, 8'h00},  // data byte before any latch
        '{CMD_TICK,  8'h00, 1'b1, 8'h00},  // all channels still silent
        '{CMD_WRITE, 8'h80, 1'b0, 8'h00},
        '{CMD_WRITE, 8'h00, 1'b0, 8'h00},
        '{CMD_WRITE, 8'h90, 1'b0, 8'h00},
        '{CMD_WRITE, 8'hB0, 1'b0, 8'h00},
        '{CMD_WRITE, 8'hD0, 1'b0, 8'h00},
        '{CMD_WRITE, 8'hF0, 1'b0, 8'h00},
        '{CMD_WRITE, 8'hA1, 1'b0, 8'h00},  // tone 1 period of one
        '{CMD_WRITE, 8'h00, 1'b0, 8'h00},
        '{CMD_WRITE, 8'hC5, 1'b0, 8'h00},
        '{CMD_WRITE, 8'h3F, 1'b0, 8'h00},  // longest upper period bits
        '{CMD_TICK,  8'hFF, 1'b0, 8'h00},
        '{CMD_WRITE, 8'hE4, 1'b0, 8'h00},  // white noise, reseeds shifter
        '{CMD_TICK,  8'h00, 1'b0, 8'h00},
        '{CMD_WRITE, 8'hEF, 1'b0, 8'h00},  // bit 3 of the noise latch dropped
        '{CMD_WRITE, 8'hC0, 1'b0, 8'h00},
        '{CMD_WRITE, 8'h00, 1'b0, 8'h00},  // tone 2 period zero
        '{CMD_TICK,  8'h00, 1'b0, 8'h00},
        '{CMD_TICK,  8'h00, 1'b0, 8'h00},
        '{CMD_WRITE, 8'hE3, 1'b0, 8'h00},
        '{CMD_WRITE, 8'h06, 1'b0, 8'h00},  // data byte into noise control
        '{CMD_TICK,  8'h00, 1'b0, 8'h00},
        '{CMD_WRITE, 8'hFF, 1'b0, 8'h00},
        '{CMD_WRITE, 8'h30, 1'b0, 8'h00},  // upper volume data bits dropped
        '{CMD_TICK,  8'h00, 1'b0, 8'h00}
    };

    task automatic apply_bus_write(input logic [7:0] b);
        logic [1:0] ch;
        logic [5:0] d;
        if (b[7])
        begin
            ch = b[6:5];
            if (b[4])
                att_r[ch] = b[3:0];
            else if (ch != CH_NOISE)
                period_r[ch][3:0] = b[3:0];
            else
                nctl_r = b[2:0];
            latch_vol_r = b[4];
            latch_ch_r  = ch;
        end
        else
        begin
            d = b[5:0];
            if (latch_vol_r)
                att_r[latch_ch_r] = d[3:0];
            else if (latch_ch_r != CH_NOISE)
                period_r[latch_ch_r][9:4] = d;
            else
                nctl_r = d[2:0];
        end
        if (!latch_vol_r && latch_ch_r == CH_NOISE)
            lfsr_r = NOISE_SEED;
    endtask

    task automatic run_tick(output logic [SAMPLE_W-1:0] mix);
        int   sum;
        logic fb;
        sum = 0;
        for (int ch = 0; ch < NUM_TONE; ch++)
        begin
            if (count_r[ch] != '0)
                count_r[ch] = count_r[ch] - PERIOD_W'(1);
            if (count_r[ch] == '0)
            begin
                count_r[ch] = period_r[ch];
                if (period_r[ch] <= 10'd1)
                begin
                    phase_r[ch] = 1'b1;
                    level_r[ch] = 1'b1;
                end
                else
                begin
                    phase_r[ch] = ~phase_r[ch];
                    level_r[ch] = phase_r[ch];
                end
            end
        end
        if (count_r[CH_NOISE] != '0)
            count_r[CH_NOISE] = count_r[CH_NOISE] - PERIOD_W'(1);
        if (count_r[CH_NOISE] == '0)
        begin
            case (nctl_r[1:0])
                RATE_16: count_r[CH_NOISE] = RELOAD_16;
                RATE_32: count_r[CH_NOISE] = RELOAD_32;
                RATE_64: count_r[CH_NOISE] = RELOAD_64;
                default: count_r[CH_NOISE] = period_r[2];
            endcase
            phase_r[CH_NOISE] = ~phase_r[CH_NOISE];
            // The shifter only moves on the rising half of the noise toggle.
            if (phase_r[CH_NOISE])
            begin
                fb = nctl_r[2] ? ^(lfsr_r & NOISE_TAPS) : lfsr_r[0];
                level_r[CH_NOISE] = lfsr_r[0];
                lfsr_r = {fb, lfsr_r[SHIFT_W-1:1]};
            end
        end
        for (int ch = 0; ch < NUM_CHAN; ch++)
            if (level_r[ch])
                sum += (255 * (int'(ATT_SILENT) - int'(att_r[ch]))) / 15 / 4;
        mix = sum[SAMPLE_W-1:0];
    endtask

    // Offers one transaction after a random gap and updates the model once
    // it has been taken. Entered and left at a falling edge.
    task automatic send(input logic cmd, input logic [7:0] data,
                        input logic typed, input logic [7:0] typed_sample);
        int                  gap;
        int                  r;
        logic [SAMPLE_W-1:0] mix;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55)
            gap = 0;
        else if (r < 90)
            gap = $urandom_range(1, 3);
        else
            gap = $urandom_range(8, 30);
        if (gap > 0)
        begin
            bus_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        bus_if.valid     <= 1'b1;
        bus_if.command   <= cmd;
        bus_if.data_byte <= data;
        do
            @(posedge clk);
        while (!bus_if.ready);
        if (cmd == CMD_TICK)
        begin
            run_tick(mix);
            expected_samples.push_back(typed ? typed_sample : mix);
        end
        else
        begin
            apply_bus_write(data);
        end
        @(negedge clk);
    endtask

    initial
    begin
        logic       cmd;
        logic [7:0] data;
        int         r;
        bus_if.valid     = 1'b0;
        bus_if.command   = CMD_WRITE;
        bus_if.data_byte = 8'h00;
        for (int ch = 0; ch < NUM_CHAN; ch++)
        begin
            att_r[ch]   = ATT_SILENT;
            count_r[ch] = '0;
            phase_r[ch] = 1'b0;
            level_r[ch] = 1'b0;
        end
        for (int ch = 0; ch < NUM_TONE; ch++)
            period_r[ch] = '0;
        nctl_r      = '0;
        lfsr_r      = '0;
        latch_vol_r = 1'b0;
        latch_ch_r  = '0;

        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed_steps[i])
            send(directed_steps[i].cmd, directed_steps[i].data,
                 directed_steps[i].typed, directed_steps[i].sample);

        for (int i = 0; i < 400; i++)
        begin
            no_idle = (i >= 150 && i < 250);
            r = $urandom_range(0, 99);
            if (r < 50)
            begin
                cmd  = CMD_TICK;
                data = 8'($urandom_range(0, 255));
            end
            else
            begin
                cmd = CMD_WRITE;
                r   = $urandom_range(0, 99);
                // Small upper period bits keep the tones toggling often.
                if (r < 55)
                    data = {1'b1, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                            4'($urandom_range(0, 15))};
                else if (r < 90)
                    data = {1'b0, 1'($urandom_range(0, 1)), 6'($urandom_range(0, 3))};
                else
                    data = {1'b0, 7'($urandom_range(0, 127))};
            end
            send(cmd, data, 1'b0, 8'h00);
        end
        no_idle = 1'b0;
        bus_if.valid <= 1'b0;

        while (expected_samples.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("[psg_tone_noise_generator_top] OK");
        else
            $display("[psg_tone_noise_generator_top] ERROR");
        $finish;
    end

    // Sample receiver: random stalls, plus one long hold-off that lets the
    // output buffer fill so that the bus side has to back off.
    initial
    begin
        int stall_left;
        int r;
        bit held;
        stall_left     = 0;
        held           = 1'b0;
        audio_if.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!held && samples_taken >= 60)
            begin
                held = 1'b1;
                audio_if.ready <= 1'b0;
                repeat (100) @(negedge clk);
            end
            else if (no_idle)
            begin
                audio_if.ready <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                audio_if.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 70)
                begin
                    audio_if.ready <= 1'b1;
                end
                else
                begin
                    audio_if.ready <= 1'b0;
                    stall_left = (r < 95) ? $urandom_range(0, 2) : $urandom_range(10, 40);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        logic [SAMPLE_W-1:0] want;
        if (rst_n && audio_if.valid && audio_if.ready)
        begin
            samples_taken++;
            if (expected_samples.size() == 0)
            begin
                if (fail_count < 10)
                    $display("%0t: sample %0d with no tick outstanding", $realtime,
                             audio_if.sample);
                fail_count++;
            end
            else
            begin
                want = expected_samples.pop_front();
                if (audio_if.sample !== want)
                begin
                    if (fail_count < 10)
                        $display("%0t: sample mismatch, expected %0d, got %0d",
                                 $realtime, want, audio_if.sample);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        #2000000;
        $display("[psg_tone_noise_generator_top] ERROR");
        $finish;
    end

endmodule

>>> sim.f
rtl/psg_pkg.sv
rtl/psg_in_if.sv
rtl/psg_out_if.sv
rtl/psg_regfile.sv
rtl/psg_channels.sv
rtl/psg_mixer.sv
rtl/psg_out_skid.sv
rtl/psg_tone_noise_generator_top.sv
bench/psg_tone_noise_generator_top_test.sv
